// File: design/shtu_pkg.sv
// ----------------------------------------------------------------------------
// shtu_pkg
// Shared types and constants for the scheduled hysteresis thermostat unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shtu_pkg;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SAMPLE    = 2'd1,
        OP_SET_CLOCK = 2'd2,
        OP_NONE      = 2'd3
    } shtu_op_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_HOUR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MINUTE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_HOUR    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_MINUTE  = 3'd5;

    localparam logic [6:0] SETPOINT_RESET = 7'd25;
    localparam logic [3:0] BAND_RESET     = 4'd5;

    localparam logic [14:0] RECIP_Q16   = 15'd32031;
    localparam logic [25:0] ROUND_HALF  = 26'd32768;
    localparam logic [9:0]  TEMP_OFFSET = 10'd50;

    localparam logic [5:0] LAST_SECOND = 6'd59;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [4:0] LAST_HOUR   = 5'd23;

    typedef struct packed {
        logic [6:0] setpoint;
        logic [3:0] band;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] stop_hour;
        logic [5:0] stop_minute;
    } shtu_cfg_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } shtu_time_t;

endpackage

// File: design/shtu_item_if.sv
// ----------------------------------------------------------------------------
// shtu_item_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shtu_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [9:0] adc_sample;
    logic       level_critical;
    logic [4:0] new_hours;
    logic [5:0] new_minutes;

    modport source (output valid, operation, adc_sample, level_critical, new_hours,
                    new_minutes, input ready);
    modport sink (input valid, operation, adc_sample, level_critical, new_hours,
                  new_minutes, output ready);
endinterface

// File: design/shtu_result_if.sv
// ----------------------------------------------------------------------------
// shtu_result_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shtu_result_if;
    logic              valid;
    logic              ready;
    logic              relay_on;
    logic signed [9:0] temperature;
    logic [4:0]        clock_hours;
    logic [5:0]        clock_minutes;
    logic [5:0]        clock_seconds;

    modport source (output valid, relay_on, temperature, clock_hours, clock_minutes,
                    clock_seconds, input ready);
    modport sink (input valid, relay_on, temperature, clock_hours, clock_minutes,
                  clock_seconds, output ready);
endinterface

// File: design/shtu_cfg_if.sv
// ----------------------------------------------------------------------------
// shtu_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shtu_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [shtu_pkg::CFG_INDEX_W-1:0] index;
    logic [shtu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/shtu_clock.sv
// ----------------------------------------------------------------------------
// shtu_clock
// Time-of-day counter: tick prescaler, seconds, minutes and hours.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shtu_clock #(
    parameter logic [6:0] TICK_LIMIT = 7'd125
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_en,
    input  logic                 set_en,
    input  logic [4:0]           new_hours,
    input  logic [5:0]           new_minutes,
    output shtu_pkg::shtu_time_t time_now,
    output shtu_pkg::shtu_time_t time_next
);

    logic [6:0] tick_reg, tick_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;

    always_comb
    begin
        tick_next = tick_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        if (tick_en)
        begin
            if (tick_reg >= TICK_LIMIT)
            begin
                tick_next = 7'd0;
                if (sec_reg >= shtu_pkg::LAST_SECOND)
                begin
                    sec_next = 6'd0;
                    if (min_reg >= shtu_pkg::LAST_MINUTE)
                    begin
                        min_next  = 6'd0;
                        hour_next = (hour_reg >= shtu_pkg::LAST_HOUR) ? 5'd0 : hour_reg + 5'd1;
                    end
                    else
                    begin
                        min_next = min_reg + 6'd1;
                    end
                end
                else
                begin
                    sec_next = sec_reg + 6'd1;
                end
            end
            else
            begin
                tick_next = tick_reg + 7'd1;
            end
        end
        else if (set_en)
        begin
            hour_next = (new_hours > shtu_pkg::LAST_HOUR) ? 5'd0 : new_hours;
            min_next  = (new_minutes > shtu_pkg::LAST_MINUTE) ? 6'd0 : new_minutes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= 7'd0;
            sec_reg  <= 6'd0;
            min_reg  <= 6'd0;
            hour_reg <= 5'd0;
        end
        else
        begin
            tick_reg <= tick_next;
            sec_reg  <= sec_next;
            min_reg  <= min_next;
            hour_reg <= hour_next;
        end
    end

    assign time_now  = '{hours: hour_reg, minutes: min_reg, seconds: sec_reg};
    assign time_next = '{hours: hour_next, minutes: min_next, seconds: sec_next};

endmodule

// File: design/shtu_relay.sv
// ----------------------------------------------------------------------------
// shtu_relay
// Temperature conversion and hysteresis relay control with heating window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shtu_relay (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_en,
    input  logic [9:0]           adc_sample,
    input  logic                 level_critical,
    input  shtu_pkg::shtu_cfg_t  cfg,
    input  shtu_pkg::shtu_time_t time_now,
    output logic                 relay_next,
    output logic signed [9:0]    temp_next
);

    logic              relay_reg;
    logic signed [9:0] temp_reg;

    logic [24:0]        product;
    logic [25:0]        rounded;
    logic [9:0]         degrees;
    logic signed [9:0]  temp_conv;
    logic signed [10:0] temp_wide;
    logic signed [10:0] low_limit;
    logic signed [10:0] high_limit;
    logic               in_window;
    logic               relay_calc;

    assign product   = 25'(adc_sample) * 25'(shtu_pkg::RECIP_Q16);
    assign rounded   = {1'b0, product} + shtu_pkg::ROUND_HALF;
    assign degrees   = rounded[25:16];
    assign temp_conv = $signed(degrees - shtu_pkg::TEMP_OFFSET);
    assign temp_wide = {temp_conv[9], temp_conv};

    assign low_limit  = $signed({4'd0, cfg.setpoint}) - $signed({7'd0, cfg.band});
    assign high_limit = $signed({4'd0, cfg.setpoint}) + $signed({7'd0, cfg.band});

    always_comb
    begin
        if (cfg.start_hour < cfg.stop_hour)
        begin
            in_window = ((time_now.hours > cfg.start_hour) ||
                         ((time_now.hours == cfg.start_hour) &&
                          (time_now.minutes > cfg.start_minute))) &&
                        ((time_now.hours < cfg.stop_hour) ||
                         ((time_now.hours == cfg.stop_hour) &&
                          (time_now.minutes < cfg.stop_minute)));
        end
        else if (time_now.hours > cfg.start_hour)
        begin
            in_window = 1'b1;
        end
        else if (time_now.hours == cfg.start_hour)
        begin
            in_window = time_now.minutes > cfg.start_minute;
        end
        else if (time_now.hours < cfg.stop_hour)
        begin
            in_window = 1'b1;
        end
        else if (time_now.hours == cfg.stop_hour)
        begin
            in_window = time_now.minutes < cfg.stop_minute;
        end
        else
        begin
            in_window = 1'b0;
        end
    end

    always_comb
    begin
        relay_calc = relay_reg;
        if (level_critical)
        begin
            relay_calc = 1'b0;
        end
        else if (temp_wide < low_limit)
        begin
            relay_calc = in_window;
        end
        else if (temp_wide > high_limit)
        begin
            relay_calc = 1'b0;
        end
    end

    assign relay_next = sample_en ? relay_calc : relay_reg;
    assign temp_next  = sample_en ? temp_conv : temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg <= 1'b0;
            temp_reg  <= 10'sd0;
        end
        else
        begin
            relay_reg <= relay_next;
            temp_reg  <= temp_next;
        end
    end

endmodule

// File: design/scheduled_hysteresis_thermostat_unit.sv
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat_unit
// Heater relay controller with a time-of-day clock and a heating window.
// ----------------------------------------------------------------------------
// The unit accepts one item in every cycle while results are taken, and returns
// one result per item. The item is held in an input register. The clock update,
// or the temperature conversion and relay decision, is done in one pass, and
// the result is then captured in an output register. The conversion multiply
// feeding the hysteresis compare sets the longest path. A waiting result
// holds the input register. Once that register is full as well, the input
// stalls until the result is taken. Configuration writes are taken in any
// cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scheduled_hysteresis_thermostat_unit #(
    parameter logic [6:0] TICK_LIMIT = 7'd125
) (
    input  logic          clk,
    input  logic          rst_n,
    shtu_item_if.sink     item,
    shtu_result_if.source result,
    shtu_cfg_if.sink      cfg
);

    shtu_pkg::shtu_cfg_t  cfg_reg;
    shtu_pkg::shtu_time_t time_now;
    shtu_pkg::shtu_time_t time_next;

    logic                item_valid_reg;
    shtu_pkg::shtu_op_t  op_reg;
    logic [9:0]          adc_reg;
    logic                crit_reg;
    logic [4:0]          new_hours_reg;
    logic [5:0]          new_minutes_reg;

    logic                res_valid_reg;
    logic                res_relay_reg;
    logic signed [9:0]   res_temp_reg;
    shtu_pkg::shtu_time_t res_time_reg;

    logic                advance;
    logic                relay_next;
    logic signed [9:0]   temp_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint     <= shtu_pkg::SETPOINT_RESET;
            cfg_reg.band         <= shtu_pkg::BAND_RESET;
            cfg_reg.start_hour   <= 5'd0;
            cfg_reg.start_minute <= 6'd0;
            cfg_reg.stop_hour    <= 5'd0;
            cfg_reg.stop_minute  <= 6'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                shtu_pkg::CFG_SETPOINT:     cfg_reg.setpoint     <= cfg.data;
                shtu_pkg::CFG_BAND:         cfg_reg.band         <= cfg.data[3:0];
                shtu_pkg::CFG_START_HOUR:   cfg_reg.start_hour   <= cfg.data[4:0];
                shtu_pkg::CFG_START_MINUTE: cfg_reg.start_minute <= cfg.data[5:0];
                shtu_pkg::CFG_STOP_HOUR:    cfg_reg.stop_hour    <= cfg.data[4:0];
                shtu_pkg::CFG_STOP_MINUTE:  cfg_reg.stop_minute  <= cfg.data[5:0];
                default: ;
            endcase
        end
    end

    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    // hold the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            op_reg          <= shtu_pkg::shtu_op_t'(item.operation);
            adc_reg         <= item.adc_sample;
            crit_reg        <= item.level_critical;
            new_hours_reg   <= item.new_hours;
            new_minutes_reg <= item.new_minutes;
        end
    end

    shtu_clock #(
        .TICK_LIMIT (TICK_LIMIT)
    ) u_clock (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (advance && (op_reg == shtu_pkg::OP_TICK)),
        .set_en      (advance && (op_reg == shtu_pkg::OP_SET_CLOCK)),
        .new_hours   (new_hours_reg),
        .new_minutes (new_minutes_reg),
        .time_now    (time_now),
        .time_next   (time_next)
    );

    shtu_relay u_relay (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_en      (advance && (op_reg == shtu_pkg::OP_SAMPLE)),
        .adc_sample     (adc_reg),
        .level_critical (crit_reg),
        .cfg            (cfg_reg),
        .time_now       (time_now),
        .relay_next     (relay_next),
        .temp_next      (temp_next)
    );

    // advance the result register; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_relay_reg <= relay_next;
            res_temp_reg  <= temp_next;
            res_time_reg  <= time_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.relay_on      = res_relay_reg;
    assign result.temperature   = res_temp_reg;
    assign result.clock_hours   = res_time_reg.hours;
    assign result.clock_minutes = res_time_reg.minutes;
    assign result.clock_seconds = res_time_reg.seconds;

endmodule
